// ===== rtl/core/multi_level_priority_ring_queue_defines.svh =====
// Assertion helpers for the priority ring queue checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef MULTI_LEVEL_PRIORITY_RING_QUEUE_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_RING_QUEUE_DEFINES_SVH

// same-cycle implication
`define MLPRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MLPRQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlprq_pkg.sv =====
`default_nettype none
package mlprq_pkg;

    localparam int LEVELS      = 5;
    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;

    localparam int PTR_W       = $clog2(DEPTH);
    localparam int SLOT_W      = $clog2(DEPTH + 1);
    localparam int LVL_W       = 3;
    localparam int LIDX_W      = $clog2(LEVELS);
    localparam int ADDR_W      = $clog2(LEVELS * DEPTH);
    localparam int OCC_W       = 7;
    localparam int REQ_W       = 3;
    localparam int ST_W        = 2;
    localparam int LU_W        = 3;
    localparam int DEPTH_REG_W = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam int IN_TDATA_W  = ((LVL_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + LVL_W + OCC_W + 7) / 8) * 8;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [ST_W-1:0]      t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [SLOT_W-1:0]    t_slots;

    localparam t_req REQ_POST    = REQ_W'(0);
    localparam t_req REQ_READ    = REQ_W'(1);
    localparam t_req REQ_CLR_ALL = REQ_W'(2);
    localparam t_req REQ_CLR_ONE = REQ_W'(3);
    localparam t_req REQ_STATUS  = REQ_W'(4);

    localparam t_status ST_OK    = ST_W'(0);
    localparam t_status ST_FULL  = ST_W'(1);
    localparam t_status ST_EMPTY = ST_W'(2);
    localparam t_status ST_RANGE = ST_W'(3);

    localparam t_cfg_idx CFG_LEVELS     = CFG_IDX_W'(0);
    localparam t_cfg_idx CFG_OVERWRITE  = CFG_IDX_W'(1);
    localparam t_cfg_idx CFG_DEPTH_LO   = CFG_IDX_W'(2);
    localparam t_cfg_idx CFG_DEPTH_HI   = CFG_IDX_W'(2 + LEVELS - 1);

    localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET = DEPTH_REG_W'(16);

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } t_cmd;

    function automatic t_slots slots_of(input logic [DEPTH_REG_W-1:0] d);
        t_slots s;
        if (d < DEPTH_REG_W'(2)) begin
            s = SLOT_W'(2);
        end else if (int'(d) > DEPTH) begin
            s = SLOT_W'(DEPTH);
        end else begin
            s = SLOT_W'(d);
        end
        return s;
    endfunction

    function automatic t_ptr advance(input t_ptr p, input t_slots d);
        t_slots q;
        q = SLOT_W'(p) + SLOT_W'(1);
        return (q >= d) ? '0 : PTR_W'(q);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/multi_level_priority_ring_queue.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: level, write_data
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: read_data, from_level,
//                                              occupancy
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One request at a time: accept, execute (pointer update and store access), finish.
// The finish step exists because the read of the element store is registered.
// A finished result may sit in the output register while the next request is accepted;
// that request then holds in its finish step until the output is taken.
// Synchronous active-low reset; no clearing pass, store contents are only read once written.
// cfg is always ready; the user must write it only while no request is in flight (not enforced here).
`default_nettype none
module multi_level_priority_ring_queue (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [2:0] level, [34:3] write_data
    input  wire logic [mlprq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  wire logic [mlprq_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [31:0] read_data, [34:32] from_level, [41:35] occupancy
    output logic      [mlprq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic      [mlprq_pkg::ST_W-1:0]           m_axis_tuser,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mlprq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mlprq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DW    = mlprq_pkg::DATA_WIDTH;
    localparam int LVL_W = mlprq_pkg::LVL_W;
    localparam int OCC_W = mlprq_pkg::OCC_W;
    localparam int PAD_W = mlprq_pkg::OUT_TDATA_W - DW - LVL_W - OCC_W;

    mlprq_pkg::t_cmd    cmd;
    mlprq_pkg::t_status status;
    logic [DW-1:0]      read_data;
    logic [LVL_W-1:0]   from_level;
    logic [OCC_W-1:0]   occupancy;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tuser = status;
    assign m_axis_tdata = {PAD_W'(0), occupancy, from_level, read_data};

    mlprq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd)
    );

    mlprq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (s_axis_tuser),
        .i_level      (s_axis_tdata[LVL_W-1:0]),
        .i_write_data (s_axis_tdata[LVL_W+DW-1:LVL_W]),
        .o_status     (status),
        .o_read_data  (read_data),
        .o_from_level (from_level),
        .o_occupancy  (occupancy)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mlprq_ram.sv =====
`default_nettype none
module mlprq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mlprq_ctrl.sv =====
`default_nettype none
module mlprq_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  wire logic        i_m_ready,
    output mlprq_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state        = r_state;
        n_m_valid      = r_m_valid && !i_m_ready;
        o_cmd.load_req = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // wait here until the result slot is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mlprq_dp.sv =====
`default_nettype none
module mlprq_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mlprq_pkg::t_cmd                     i_cmd,
    input  wire logic                                i_cfg_we,
    input  wire mlprq_pkg::t_cfg_idx                 i_cfg_index,
    input  wire logic [mlprq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire mlprq_pkg::t_req                     i_req_type,
    input  wire logic [mlprq_pkg::LVL_W-1:0]         i_level,
    input  wire logic [mlprq_pkg::DATA_WIDTH-1:0]    i_write_data,
    output mlprq_pkg::t_status                       o_status,
    output logic      [mlprq_pkg::DATA_WIDTH-1:0]    o_read_data,
    output logic      [mlprq_pkg::LVL_W-1:0]         o_from_level,
    output logic      [mlprq_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int LEVELS = mlprq_pkg::LEVELS;
    localparam int LIDX_W = mlprq_pkg::LIDX_W;
    localparam int LVL_W  = mlprq_pkg::LVL_W;
    localparam int ADDR_W = mlprq_pkg::ADDR_W;
    localparam int OCC_W  = mlprq_pkg::OCC_W;
    localparam int SLOT_W = mlprq_pkg::SLOT_W;
    localparam int DW     = mlprq_pkg::DATA_WIDTH;

    // configuration
    logic [mlprq_pkg::LU_W-1:0]        r_levels_used;
    logic [LEVELS-1:0]                 r_ovw_mask;
    logic [mlprq_pkg::DEPTH_REG_W-1:0] r_depth [LEVELS];

    // ring pointers
    mlprq_pkg::t_ptr r_rp [LEVELS];
    mlprq_pkg::t_ptr r_wp [LEVELS];
    mlprq_pkg::t_ptr n_rp [LEVELS];
    mlprq_pkg::t_ptr n_wp [LEVELS];

    // request held for execution
    mlprq_pkg::t_req    r_req;
    logic [LVL_W-1:0]   r_lvl;
    logic [DW-1:0]      r_wdata;

    // execution outcome, awaiting read data
    mlprq_pkg::t_status r_status, n_status;
    logic [LVL_W-1:0]   r_from, n_from;
    logic               r_rd_ok, n_rd_ok;

    logic [LVL_W-1:0]   act_n;
    logic               lv_ok;
    logic [LIDX_W-1:0]  sel;
    mlprq_pkg::t_slots  post_d;
    mlprq_pkg::t_ptr    post_nw;
    logic               post_full;
    logic               found;
    logic [LIDX_W-1:0]  rsel;
    logic               cfg_depth;
    logic [LIDX_W-1:0]  cfg_lv;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [DW-1:0]      ram_q;

    logic [OCC_W-1:0]   occ;

    always_comb begin
        if (r_levels_used == '0) begin
            act_n = LVL_W'(1);
        end else if (int'(r_levels_used) > LEVELS) begin
            act_n = LVL_W'(LEVELS);
        end else begin
            act_n = LVL_W'(r_levels_used);
        end
    end

    assign lv_ok     = (r_lvl < act_n);
    assign sel       = lv_ok ? r_lvl[LIDX_W-1:0] : '0;
    assign post_d    = mlprq_pkg::slots_of(r_depth[sel]);
    assign post_nw   = mlprq_pkg::advance(r_wp[sel], post_d);
    assign post_full = (post_nw == r_rp[sel]);

    // highest-priority non-empty level in use
    always_comb begin
        found = 1'b0;
        rsel  = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (!found && (LVL_W'(i) < act_n) && (r_rp[i] != r_wp[i])) begin
                found = 1'b1;
                rsel  = LIDX_W'(i);
            end
        end
    end

    assign cfg_depth = i_cfg_we &&
                       (i_cfg_index inside {[mlprq_pkg::CFG_DEPTH_LO:mlprq_pkg::CFG_DEPTH_HI]});
    assign cfg_lv    = LIDX_W'(i_cfg_index - mlprq_pkg::CFG_DEPTH_LO);

    assign ram_waddr = ADDR_W'(sel) * ADDR_W'(mlprq_pkg::DEPTH) + ADDR_W'(r_wp[sel]);
    assign ram_raddr = ADDR_W'(rsel) * ADDR_W'(mlprq_pkg::DEPTH) + ADDR_W'(r_rp[rsel]);

    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_status = r_status;
        n_from   = r_from;
        n_rd_ok  = r_rd_ok;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        if (i_cmd.exec) begin
            n_status = mlprq_pkg::ST_OK;
            n_from   = '0;
            n_rd_ok  = 1'b0;
            case (r_req)
                mlprq_pkg::REQ_POST: begin
                    if (!lv_ok) begin
                        n_status = mlprq_pkg::ST_RANGE;
                    end else if (post_full && !r_ovw_mask[sel]) begin
                        n_status = mlprq_pkg::ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        n_wp[sel] = post_nw;
                        // full with overwrite: drop the oldest word
                        if (post_full) begin
                            n_rp[sel] = mlprq_pkg::advance(r_rp[sel], post_d);
                        end
                    end
                end
                mlprq_pkg::REQ_READ: begin
                    if (found) begin
                        ram_re     = 1'b1;
                        n_rp[rsel] = mlprq_pkg::advance(r_rp[rsel],
                                                        mlprq_pkg::slots_of(r_depth[rsel]));
                        n_from     = LVL_W'(rsel);
                        n_rd_ok    = 1'b1;
                    end else begin
                        n_status = mlprq_pkg::ST_EMPTY;
                    end
                end
                mlprq_pkg::REQ_CLR_ALL: begin
                    for (int i = 0; i < LEVELS; i++) begin
                        if (LVL_W'(i) < act_n) begin
                            n_rp[i] = '0;
                            n_wp[i] = '0;
                        end
                    end
                end
                mlprq_pkg::REQ_CLR_ONE: begin
                    if (!lv_ok) begin
                        n_status = mlprq_pkg::ST_RANGE;
                    end else begin
                        n_rp[sel] = '0;
                        n_wp[sel] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        // a depth write empties its level
        if (cfg_depth) begin
            n_rp[cfg_lv] = '0;
            n_wp[cfg_lv] = '0;
        end
    end

    always_comb begin
        logic [SLOT_W-1:0] cnt;
        occ = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_wp[i] >= r_rp[i]) begin
                cnt = SLOT_W'(r_wp[i]) - SLOT_W'(r_rp[i]);
            end else begin
                cnt = SLOT_W'(r_wp[i]) + mlprq_pkg::slots_of(r_depth[i]) - SLOT_W'(r_rp[i]);
            end
            if (LVL_W'(i) < act_n) begin
                occ = occ + OCC_W'(cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels_used <= mlprq_pkg::LU_W'(1);
            r_ovw_mask    <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_depth[i] <= mlprq_pkg::DEPTH_RESET;
                r_rp[i]    <= '0;
                r_wp[i]    <= '0;
            end
            r_status <= mlprq_pkg::ST_OK;
            r_from   <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_status <= n_status;
            r_from   <= n_from;
            r_rd_ok  <= n_rd_ok;
            if (i_cfg_we && (i_cfg_index == mlprq_pkg::CFG_LEVELS)) begin
                r_levels_used <= i_cfg_data[mlprq_pkg::LU_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == mlprq_pkg::CFG_OVERWRITE)) begin
                r_ovw_mask <= i_cfg_data[LEVELS-1:0];
            end
            if (cfg_depth) begin
                r_depth[cfg_lv] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_req_type;
            r_lvl   <= i_level;
            r_wdata <= i_write_data;
        end
        if (i_cmd.load_out) begin
            o_status     <= r_status;
            o_read_data  <= r_rd_ok ? ram_q : '0;
            o_from_level <= r_from;
            o_occupancy  <= occ;
        end
    end

    mlprq_ram #(
        .WIDTH (DW),
        .DEPTH (LEVELS * mlprq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mlprq_checker.sv =====
`default_nettype none
`include "multi_level_priority_ring_queue_defines.svh"
module mlprq_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    input  wire logic                                 s_axis_tready,
    input  wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic [mlprq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [mlprq_pkg::ST_W-1:0]           m_axis_tuser
);

    logic op_failed;

    assign op_failed = m_axis_tvalid && (m_axis_tuser != mlprq_pkg::ST_OK);

    // a result stays offered until transferred
    `MLPRQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

    // one request in flight: no transfer in the cycle after one
    `MLPRQ_ASSERT_NXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input not busy")

    // only a successful read carries data or a source level
    `MLPRQ_ASSERT_IMP(a_rd_zero, op_failed, m_axis_tdata[34:0] == 35'd0, "data on failed op")

    // occupancy never exceeds five levels of fifteen words
    `MLPRQ_ASSERT_IMP(a_occ_max, m_axis_tvalid, m_axis_tdata[41:35] <= 7'd75, "occupancy too high")

endmodule

bind multi_level_priority_ring_queue mlprq_checker u_mlprq_checker (.*);
`default_nettype wire
